FILE: design/ospt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ospt_pkg
// Types, codes and constants shared by the timer pool modules.
// ----------------------------------------------------------------------------
package ospt_pkg;

	localparam int NUM_TIMERS_DEF = 16;
	localparam logic [7:0] TPU_RESET = 8'd10;

	localparam logic [2:0] OP_CREATE  = 3'd0;
	localparam logic [2:0] OP_START   = 3'd1;
	localparam logic [2:0] OP_STOP    = 3'd2;
	localparam logic [2:0] OP_DELETE  = 3'd3;
	localparam logic [2:0] OP_TICK    = 3'd4;
	localparam logic [2:0] OP_REMAIN  = 3'd5;
	localparam logic [2:0] OP_STATE   = 3'd6;
	localparam logic [2:0] OP_ILLEGAL = 3'd7;

	localparam logic [1:0] SM_SILENT  = 2'd0;
	localparam logic [1:0] SM_NOTIFY  = 2'd1;
	localparam logic [1:0] SM_ARG     = 2'd2;
	localparam logic [1:0] SM_INVALID = 2'd3;

	localparam logic [1:0] ST_UNUSED    = 2'd0;
	localparam logic [1:0] ST_STOPPED   = 2'd1;
	localparam logic [1:0] ST_RUNNING   = 2'd2;
	localparam logic [1:0] ST_COMPLETED = 2'd3;

	localparam logic [1:0] KIND_REPLY  = 2'd0;
	localparam logic [1:0] KIND_EVENT  = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;

	localparam logic [3:0] STS_OK       = 4'd0;
	localparam logic [3:0] STS_BADH     = 4'd1;
	localparam logic [3:0] STS_INACTIVE = 4'd2;
	localparam logic [3:0] STS_BADOPT   = 4'd3;
	localparam logic [3:0] STS_BADDLY   = 4'd4;
	localparam logic [3:0] STS_BADPER   = 4'd5;
	localparam logic [3:0] STS_NOFREE   = 4'd6;
	localparam logic [3:0] STS_STOPPED  = 4'd7;
	localparam logic [3:0] STS_NOHAND   = 4'd8;

	localparam logic [1:0] MODE_ONESHOT  = 2'd1;
	localparam logic [1:0] MODE_PERIODIC = 2'd2;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [3:0]  slot_id;
		logic [15:0] delay_units;
		logic [15:0] period_units;
		logic [1:0]  mode_code;
		logic        has_handler;
		logic [1:0]  stop_mode;
		logic        arg_present;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  handle;
		logic [3:0]  status;
		logic [31:0] value;
		logic        last;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE, S_CMD, S_SCAN, S_DONE, S_OUT
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;     // capture request
		logic exec;     // run one non-tick command, emit reply
		logic tick_inc; // advance counter, reset scan index
		logic scan;     // examine one slot
		logic done;     // emit tick done item
		logic out_pop;  // output register taken
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic is_tick;
		logic scan_last;
		logic out_full;
		logic pend;     // a second result waits behind the output register
	} sts_t;

endpackage
`default_nettype wire

FILE: design/ospt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ospt_ctrl
// Sequencer: command, tick scan and output hand-off.
// ----------------------------------------------------------------------------
module ospt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_fire,
	input  wire logic          out_fire,
	input  wire ospt_pkg::sts_t sts,
	output ospt_pkg::cmd_t     cmd,
	output logic               busy
);
	import ospt_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.out_pop = out_fire;
		busy = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d = S_CMD;
				end
			end
			S_CMD: begin
				if (sts.is_tick) begin
					cmd.tick_inc = 1'b1;
					state_d = S_SCAN;
				end else if (!sts.out_full || out_fire) begin
					cmd.exec = 1'b1;
					state_d = S_OUT;
				end
			end
			S_SCAN: begin
				if (!sts.out_full || out_fire) begin
					cmd.scan = 1'b1;
					if (sts.scan_last) state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!sts.out_full || out_fire) begin
					cmd.done = 1'b1;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!sts.pend && (!sts.out_full || out_fire)) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

FILE: design/ospt_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ospt_dp
// Timer slot storage, tick counter and result register.
// ----------------------------------------------------------------------------
module ospt_dp #(
	parameter int NUM_TIMERS = ospt_pkg::NUM_TIMERS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire ospt_pkg::cmd_t cmd,
	input  wire ospt_pkg::req_t req,
	input  wire logic [7:0]     tpu,
	output ospt_pkg::sts_t      sts,
	output ospt_pkg::rsp_t      rsp,
	output logic                rsp_valid
);
	import ospt_pkg::*;

	localparam int SLOTS = (NUM_TIMERS < 16) ? NUM_TIMERS : 16;
	localparam int IW = 4;

	req_t        r_q;
	logic [31:0] tick_q;
	logic [4:0]  free_q;
	logic [1:0]  st_q [SLOTS];
	logic [1:0]  fl_q [SLOTS];
	logic [31:0] dly_q [SLOTS];
	logic [31:0] per_q [SLOTS];
	logic [31:0] mat_q [SLOTS];
	logic [IW-1:0] idx_q;
	rsp_t        out_q;
	logic        full_q;
	rsp_t        pend_q;
	logic        pend_v_q;

	logic        ok_id;
	logic [1:0]  cst;
	logic [IW-1:0] free_i;
	logic        any_free;
	logic [31:0] m_dly, m_per;
	logic        hit;
	logic        load_out;

	assign ok_id = ({1'b0, r_q.slot_id} < 5'(SLOTS));
	assign cst = ok_id ? st_q[r_q.slot_id] : ST_UNUSED;
	assign m_dly = {16'd0, r_q.delay_units} * {24'd0, tpu};
	assign m_per = {16'd0, r_q.period_units} * {24'd0, tpu};

	// A scanned slot that expires on this tick.
	assign hit = cmd.scan && st_q[idx_q] == ST_RUNNING && mat_q[idx_q] == tick_q;
	// Any new result written into the output register this cycle.
	assign load_out = hit || cmd.done || cmd.exec;

	always_comb begin
		free_i = '0;
		any_free = 1'b0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (st_q[i] == ST_UNUSED) begin
				free_i = IW'(i);
				any_free = 1'b1;
			end
		end
	end

	assign sts.is_tick = (r_q.opcode == OP_TICK);
	assign sts.scan_last = ({1'b0, idx_q} == 5'(SLOTS - 1));
	assign sts.out_full = full_q;
	assign sts.pend = pend_v_q;
	assign rsp = out_q;
	assign rsp_valid = full_q;

	function automatic rsp_t mk(input logic [1:0] k, input logic [3:0] h,
			input logic [3:0] s, input logic [31:0] v, input logic l);
		rsp_t x;
		x.kind = k; x.handle = h; x.status = s; x.value = v; x.last = l;
		return x;
	endfunction

	// Reply for a non-tick command and whether a notify precedes it.
	rsp_t  rep;
	logic  notify;
	always_comb begin
		rep = mk(KIND_REPLY, r_q.slot_id, STS_OK, 32'd0, 1'b1);
		notify = 1'b0;
		if (r_q.opcode == OP_CREATE) begin
			rep.handle = '0;
			if (r_q.mode_code == MODE_ONESHOT && r_q.delay_units == 16'd0)
				rep.status = STS_BADDLY;
			else if (r_q.mode_code == MODE_PERIODIC && r_q.period_units == 16'd0)
				rep.status = STS_BADPER;
			else if (r_q.mode_code != MODE_ONESHOT && r_q.mode_code != MODE_PERIODIC)
				rep.status = STS_BADOPT;
			else if (!any_free)
				rep.status = STS_NOFREE;
			else
				rep.handle = 4'(free_i);
		end else if (r_q.opcode == OP_ILLEGAL) begin
			rep.status = STS_BADOPT;
		end else if (!ok_id) begin
			rep.status = STS_BADH;
		end else if (cst == ST_UNUSED) begin
			rep.status = STS_INACTIVE;
		end else begin
			case (r_q.opcode)
				OP_STOP: begin
					if (r_q.stop_mode == SM_INVALID) rep.status = STS_BADOPT;
					else if (cst == ST_STOPPED) rep.status = STS_STOPPED;
					else if (r_q.stop_mode != SM_SILENT && !fl_q[r_q.slot_id][0])
						rep.status = STS_NOHAND;
					else if (r_q.stop_mode == SM_ARG && !r_q.arg_present)
						rep.status = STS_NOHAND;
					else notify = (r_q.stop_mode != SM_SILENT);
				end
				OP_REMAIN: rep.value = mat_q[r_q.slot_id] - tick_q;
				OP_STATE:  rep.value = {30'd0, cst};
				default: ;
			endcase
		end
	end

	logic [31:0] tick_n;
	assign tick_n = tick_q + 32'd1;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			free_q <= 5'(SLOTS);
			full_q <= 1'b0;
			pend_v_q <= 1'b0;
			idx_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				st_q[i] <= ST_UNUSED;
				fl_q[i] <= '0;
			end
		end else begin
			if (load_out) full_q <= 1'b1;
			else if (cmd.out_pop) full_q <= pend_v_q;
			if (cmd.exec) pend_v_q <= notify;
			else if (cmd.out_pop) pend_v_q <= 1'b0;
			if (cmd.tick_inc) begin
				tick_q <= tick_n;
				idx_q <= '0;
			end
			if (cmd.scan) idx_q <= idx_q + IW'(1);
			if (hit) st_q[idx_q] <= fl_q[idx_q][1] ? ST_RUNNING : ST_COMPLETED;
			if (cmd.exec) begin
				if (r_q.opcode == OP_CREATE && rep.status == STS_OK) begin
					st_q[free_i] <= ST_STOPPED;
					fl_q[free_i] <= {r_q.mode_code == MODE_PERIODIC, r_q.has_handler};
					if (free_q != 5'd0) free_q <= free_q - 5'd1;
				end else if (ok_id && cst != ST_UNUSED && r_q.opcode != OP_ILLEGAL) begin
					if (r_q.opcode == OP_START) st_q[r_q.slot_id] <= ST_RUNNING;
					else if (r_q.opcode == OP_STOP && rep.status == STS_OK)
						st_q[r_q.slot_id] <= ST_STOPPED;
					else if (r_q.opcode == OP_DELETE) begin
						st_q[r_q.slot_id] <= ST_UNUSED;
						fl_q[r_q.slot_id] <= '0;
						if (free_q < 5'(SLOTS)) free_q <= free_q + 5'd1;
					end
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) r_q <= req;
		if (cmd.out_pop && !load_out) out_q <= pend_q;
		if (cmd.exec) begin
			if (notify) begin
				out_q <= mk(KIND_EVENT, r_q.slot_id, STS_OK, 32'd0, 1'b0);
				pend_q <= rep;
			end else out_q <= rep;
			if (r_q.opcode == OP_CREATE && rep.status == STS_OK) begin
				dly_q[free_i] <= m_dly;
				per_q[free_i] <= m_per;
				mat_q[free_i] <= '0;
			end else if (ok_id && cst != ST_UNUSED && r_q.opcode == OP_START) begin
				if (fl_q[r_q.slot_id][1]) begin
					mat_q[r_q.slot_id] <= tick_q + ((dly_q[r_q.slot_id] == 32'd0)
						? per_q[r_q.slot_id] : dly_q[r_q.slot_id]);
					dly_q[r_q.slot_id] <= '0;
				end else mat_q[r_q.slot_id] <= tick_q + dly_q[r_q.slot_id];
			end else if (ok_id && cst != ST_UNUSED && r_q.opcode == OP_DELETE) begin
				dly_q[r_q.slot_id] <= '0;
				per_q[r_q.slot_id] <= '0;
			end
		end
		if (hit) begin
			out_q <= mk(KIND_EVENT, 4'(idx_q), fl_q[idx_q][0] ? STS_OK : STS_NOHAND,
				32'd0, 1'b0);
			if (fl_q[idx_q][1]) begin
				mat_q[idx_q] <= tick_q + ((dly_q[idx_q] == 32'd0)
					? per_q[idx_q] : dly_q[idx_q]);
				dly_q[idx_q] <= '0;
			end
		end
		if (cmd.done) out_q <= mk(KIND_DONE, 4'd0, STS_OK, tick_q, 1'b1);
	end

	a_pend_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> full_q) else $error("pending result without output");
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= 5'(SLOTS)) else $error("free count out of range");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.done) |-> (out_q.kind == KIND_DONE && out_q.last))
		else $error("done item malformed");

endmodule
`default_nettype wire

FILE: design/one_shot_periodic_timer_pool_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// one_shot_periodic_timer_pool_core
// Command driven pool of one-shot and periodic timers.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_stall as one req_t; results leave on
// out_valid/out_stall as rsp_t items, the last of each request marked last.
// The block takes one request at a time. A plain command runs through
// capture, execute and hand-off of the reply. A stop that notifies
// sends two items. A tick advances the 32-bit counter and then scans one
// slot per cycle while the output register can take a result. Every slot
// that matches sends an expiry item, and the tick ends with a done item
// carrying the new count. When the receiver stalls, the result stays in
// the output register and the scan waits. The ticks_per_unit register
// is written on cfg_valid and cfg_ready and is read at create. Reset
// clears the counter, frees all slots and sets ticks_per_unit to ten.
// ----------------------------------------------------------------------------
module one_shot_periodic_timer_pool_core #(
	parameter int NUM_TIMERS = ospt_pkg::NUM_TIMERS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire ospt_pkg::req_t in_data,
	output logic                out_valid,
	input  wire logic           out_stall,
	output ospt_pkg::rsp_t      out_data,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire logic [7:0]     cfg_data
);
	import ospt_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic busy;
	logic [7:0] tpu_q;

	assign in_stall = busy;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tpu_q <= TPU_RESET;
		else if (cfg_valid) tpu_q <= cfg_data;
	end

	ospt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(in_valid && !busy),
		.out_fire(out_valid && !out_stall),
		.sts(sts), .cmd(cmd), .busy(busy)
	);

	ospt_dp #(.NUM_TIMERS(NUM_TIMERS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .req(in_data), .tpu(tpu_q),
		.sts(sts), .rsp(out_data), .rsp_valid(out_valid)
	);

endmodule
`default_nettype wire
